[rtl/core/smf_pkg.sv]
// ----------------------------------------------------------------------------
// smf_pkg
// shared types and constants of the sliding median filter
// ----------------------------------------------------------------------------
package smf_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int MAX_WINDOW   = 15;
  localparam int WINDOW_LIMIT = 15;
  localparam int WIN_W        = 4;
  localparam int RESET_WINDOW = 3;
  localparam int FILL_W       = $clog2(MAX_WINDOW + 1);
  localparam int RANK_W       = $clog2(MAX_WINDOW);
  localparam int Q_DEPTH      = 4;
  localparam int Q_PTR_W      = $clog2(Q_DEPTH);
  localparam int Q_CNT_W      = $clog2(Q_DEPTH + 1);

  typedef logic [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic [WIN_W-1:0]        win_t;

  // one queued median plus the number of edge repeats behind it
  typedef struct packed {
    sample_t median;
    logic    last;
    win_t    rpt;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_push_t;

  typedef struct packed {
    logic [Q_CNT_W-1:0] count;
    logic               empty;
  } q_stat_t;

  // odd and within the supported range
  function automatic logic window_ok(win_t w);
    return w[0] && (int'(w) <= WINDOW_LIMIT) && (int'(w) <= MAX_WINDOW);
  endfunction

endpackage

[rtl/core/smf_in_if.sv]
// ----------------------------------------------------------------------------
// smf_in_if
// sample input channel
// ----------------------------------------------------------------------------
interface smf_in_if;
  logic                                    valid;
  logic                                    ready;
  logic [smf_pkg::SAMPLE_WIDTH-1:0]        sample_in;
  logic                                    last_sample;

  modport source (output valid, output sample_in, output last_sample, input ready);
  modport sink   (input valid, input sample_in, input last_sample, output ready);
endinterface

[rtl/core/smf_out_if.sv]
// ----------------------------------------------------------------------------
// smf_out_if
// median result channel
// ----------------------------------------------------------------------------
interface smf_out_if;
  logic                                    valid;
  logic                                    ready;
  logic [smf_pkg::SAMPLE_WIDTH-1:0]        median_out;
  logic                                    last_result;

  modport source (output valid, output median_out, output last_result, input ready);
  modport sink   (input valid, input median_out, input last_result, output ready);
endinterface

[rtl/core/smf_cfg_if.sv]
// ----------------------------------------------------------------------------
// smf_cfg_if
// window size write channel
// ----------------------------------------------------------------------------
interface smf_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [smf_pkg::WIN_W-1:0]    window_size;

  modport source (output valid, output window_size, input ready);
  modport sink   (input valid, input window_size, output ready);
endinterface

[rtl/core/smf_front.sv]
// ----------------------------------------------------------------------------
// smf_front
// sample window, fill tracking and rank-compare median
// ----------------------------------------------------------------------------
module smf_front (
  input  logic                 clk,
  input  logic                 rst_n,
  smf_in_if.sink               in_ch,
  input  smf_pkg::win_t        window_size,
  input  smf_pkg::q_stat_t     q_stat,
  output smf_pkg::q_push_t     q_push
);

  smf_pkg::sample_t                 window_r [smf_pkg::MAX_WINDOW];
  logic [smf_pkg::FILL_W-1:0]       fill_r, fill_nxt, fill_inc;
  logic                             job_r, job_nxt;
  smf_pkg::win_t                    job_w_r;
  logic                             job_last_r;
  logic                             accept;
  logic                             emit;

  logic [smf_pkg::MAX_WINDOW-1:0]   lt_m [smf_pkg::MAX_WINDOW];
  logic [smf_pkg::RANK_W-1:0]       rank_c [smf_pkg::MAX_WINDOW];
  logic [smf_pkg::MAX_WINDOW-1:0]   sel_c;
  smf_pkg::sample_t                 med_c;
  logic [smf_pkg::RANK_W-1:0]       mid_rank;

  // reserve a queue slot for the job still in the median stage
  assign in_ch.ready = (int'(q_stat.count) + int'(job_r)) < smf_pkg::Q_DEPTH;
  assign accept      = in_ch.valid && in_ch.ready;

  assign fill_inc = (int'(fill_r) < smf_pkg::MAX_WINDOW) ? fill_r + 1'b1 : fill_r;
  assign emit     = smf_pkg::window_ok(window_size) &&
                    (int'(fill_inc) >= int'(window_size));

  always_comb begin
    fill_nxt = fill_r;
    job_nxt  = 1'b0;
    if (accept) begin
      fill_nxt = in_ch.last_sample ? '0 : fill_inc;
      job_nxt  = emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      job_r  <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      job_r  <= job_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = smf_pkg::MAX_WINDOW - 1; i > 0; i--) begin
        window_r[i] <= window_r[i-1];
      end
      window_r[0] <= in_ch.sample_in;
      job_w_r     <= window_size;
      job_last_r  <= in_ch.last_sample;
    end
  end

  // rank of each entry among the newest job_w_r, ties broken by position
  assign mid_rank = smf_pkg::RANK_W'(job_w_r >> 1);

  always_comb begin
    med_c = '0;
    for (int i = 0; i < smf_pkg::MAX_WINDOW; i++) begin
      for (int j = 0; j < smf_pkg::MAX_WINDOW; j++) begin
        lt_m[i][j] = (j < int'(job_w_r)) &&
                     ((window_r[j] < window_r[i]) ||
                      ((window_r[j] == window_r[i]) && (j < i)));
      end
      rank_c[i] = smf_pkg::RANK_W'($countones(lt_m[i]));
      sel_c[i]  = (i < int'(job_w_r)) && (rank_c[i] == mid_rank);
      med_c     = med_c | ({smf_pkg::SAMPLE_WIDTH{sel_c[i]}} & window_r[i]);
    end
  end

  always_comb begin
    q_push.valid        = job_r;
    q_push.entry.median = med_c;
    q_push.entry.last   = job_last_r;
    q_push.entry.rpt    = job_last_r ? job_w_r - 1'b1 : '0;
  end

endmodule

[rtl/core/smf_queue.sv]
// ----------------------------------------------------------------------------
// smf_queue
// small fifo of median jobs between front and back
// ----------------------------------------------------------------------------
module smf_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  smf_pkg::q_push_t     q_push,
  input  logic                 q_pop,
  output smf_pkg::q_entry_t    q_head,
  output smf_pkg::q_stat_t     q_stat
);

  smf_pkg::q_entry_t               mem [smf_pkg::Q_DEPTH];
  logic [smf_pkg::Q_PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [smf_pkg::Q_PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [smf_pkg::Q_CNT_W-1:0]     count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = q_push.valid ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + smf_pkg::Q_CNT_W'(q_push.valid) - smf_pkg::Q_CNT_W'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push.valid) begin
      mem[wr_ptr_r] <= q_push.entry;
    end
  end

  assign q_head       = mem[rd_ptr_r];
  assign q_stat.count = count_r;
  assign q_stat.empty = (count_r == '0);

endmodule

[rtl/core/smf_back.sv]
// ----------------------------------------------------------------------------
// smf_back
// result emitter with edge repeats
// ----------------------------------------------------------------------------
module smf_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  smf_pkg::q_entry_t    q_head,
  input  smf_pkg::q_stat_t     q_stat,
  output logic                 q_pop,
  smf_out_if.source            out_ch
);

  logic                valid_r, valid_nxt;
  logic                last_r, last_nxt;
  smf_pkg::sample_t    median_r, median_nxt;
  smf_pkg::win_t       rem_r, rem_nxt;
  logic                advance;

  assign advance = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt  = valid_r;
    last_nxt   = last_r;
    median_nxt = median_r;
    rem_nxt    = rem_r;
    q_pop      = 1'b0;
    if (advance) begin
      if (rem_r != '0) begin
        // repeats only follow a last sample
        valid_nxt = 1'b1;
        last_nxt  = (rem_r == smf_pkg::WIN_W'(1));
        rem_nxt   = rem_r - 1'b1;
      end else if (!q_stat.empty) begin
        q_pop      = 1'b1;
        valid_nxt  = 1'b1;
        median_nxt = q_head.median;
        last_nxt   = q_head.last && (q_head.rpt == '0);
        rem_nxt    = q_head.rpt;
      end else begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rem_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      rem_r   <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r   <= last_nxt;
    median_r <= median_nxt;
  end

  assign out_ch.valid       = valid_r;
  assign out_ch.median_out  = median_r;
  assign out_ch.last_result = last_r;

endmodule

[rtl/core/sliding_median_filter_core.sv]
// ----------------------------------------------------------------------------
// sliding_median_filter_core
// streaming median filter over a sliding window of samples
// ----------------------------------------------------------------------------
// in_ch takes one sample per transaction, last_sample marks a sequence end.
// out_ch gives one median per transaction, last_result marks the final one.
// cfg_ch writes window_size (odd, 1 to 15); write it only while idle.
// once the window holds window_size samples of the sequence, each sample
// yields one median; the last sample adds window_size-1 repeats of it.
// short sequences and even window sizes give no results.
// a median is ranked over the window registers, queued, then registered for
// out_ch. throughput: one sample per cycle while the job queue has room, set
// by the combinational rank-compare; a last sample occupies the output for
// window_size results while the 4-entry job queue keeps taking samples.
// receiver stall: the output register holds, the queue fills, then in_ch
// ready drops. reset: window size 3, fill count and queue cleared, no
// output pending. cfg_ch is always ready.
// ----------------------------------------------------------------------------
module sliding_median_filter_core (
  input  logic       clk,
  input  logic       rst_n,
  smf_in_if.sink     in_ch,
  smf_out_if.source  out_ch,
  smf_cfg_if.sink    cfg_ch
);

  // configuration register
  smf_pkg::win_t       window_size_r, window_size_nxt;

  // front to queue to back
  smf_pkg::q_push_t    q_push;
  smf_pkg::q_entry_t   q_head;
  smf_pkg::q_stat_t    q_stat;
  logic                q_pop;

  assign cfg_ch.ready = 1'b1;

  // window size write transaction
  assign window_size_nxt = cfg_ch.valid ? cfg_ch.window_size : window_size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= smf_pkg::win_t'(smf_pkg::RESET_WINDOW);
    end else begin
      window_size_r <= window_size_nxt;
    end
  end

  // front: shifts the window, decides whether a median is due, ranks it
  smf_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .window_size (window_size_r),
    .q_stat      (q_stat),
    .q_push      (q_push)
  );

  // job queue decouples sample intake from result delivery
  smf_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .q_pop  (q_pop),
    .q_head (q_head),
    .q_stat (q_stat)
  );

  // back: emits the median and the edge repeats
  smf_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_head (q_head),
    .q_stat (q_stat),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

`ifndef ASSERT_OFF
  // the slot reservation in the front must keep the queue from overflowing
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push.valid && !q_pop) |-> (int'(q_stat.count) < smf_pkg::Q_DEPTH))
    else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("job queue underflow");

  // a result register never survives reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid right after reset");
`endif

endmodule

[test/sliding_median_filter_core_tb.sv]
// ----------------------------------------------------------------------------
// sliding_median_filter_core_tb
// self-checking bench for the streaming median filter
// ----------------------------------------------------------------------------
// samples go in as transactions on in_ch and medians are checked on out_ch
// against a predictor that keeps its own copy of the sample window, fill
// count and window size. a short directed part covers the extremes, short
// sequences, a window of one and a size change inside an open sequence.
// random sequences follow under many window sizes, odd and even, with
// random idle on the sender and random stall on the receiver.
// ----------------------------------------------------------------------------
module sliding_median_filter_core_tb;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 360;
  localparam int PHASE_ITEMS   = 30;
  localparam int DEAD_ITEMS    = 8;

  typedef struct packed {
    smf_pkg::sample_t sample;
    logic             last;
  } sample_item_t;

  typedef struct packed {
    smf_pkg::sample_t median;
    logic             last;
  } median_item_t;

  // window sizes visited by the random part, odd and even, extremes included
  localparam smf_pkg::win_t WIN_PLAN [13] = '{4'd5, 4'd15, 4'd1, 4'd14, 4'd7, 4'd9,
                                              4'd0, 4'd13, 4'd3, 4'd11, 4'd2, 4'd15,
                                              4'd1};
  // idle limits picked per phase: none, light, heavy
  localparam int PACE [3] = '{0, 3, 16};

  logic clk;
  logic rst_n;

  smf_in_if  in_ch ();
  smf_out_if out_ch ();
  smf_cfg_if cfg_ch ();

  sliding_median_filter_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // predictor state
  smf_pkg::sample_t win_hist [smf_pkg::MAX_WINDOW];   // entry 0 is the newest sample
  int               fill_cnt;
  smf_pkg::win_t    cur_win;

  sample_item_t sample_backlog [$];
  median_item_t expected_medians [$];

  // handshake flags, set at the rising edge, read at the falling edge
  logic in_took;
  logic out_took;
  int   in_gap;
  int   out_stall;
  int   in_gap_max;
  int   out_stall_max;
  int   errors;
  int   cycle_cnt;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // shift the sample in and queue every median it gives rise to
  task automatic compute_medians(input smf_pkg::sample_t s, input logic last);
    smf_pkg::sample_t sorted [smf_pkg::MAX_WINDOW];
    smf_pkg::sample_t v;
    median_item_t     r;
    int               w;
    int               i;
    int               j;
    w = int'(cur_win);
    for (i = smf_pkg::MAX_WINDOW - 1; i > 0; i--)
      win_hist[i] = win_hist[i-1];
    win_hist[0] = s;
    if (fill_cnt < smf_pkg::MAX_WINDOW)
      fill_cnt++;
    // odd sizes only; a 4-bit size never exceeds 15
    if (cur_win[0] && fill_cnt >= w) begin
      // insertion sort of the newest w samples
      for (i = 0; i < w; i++) begin
        v = win_hist[i];
        j = i;
        while (j > 0 && sorted[j-1] > v) begin
          sorted[j] = sorted[j-1];
          j--;
        end
        sorted[j] = v;
      end
      r.median = sorted[w/2];
      r.last   = last && (w == 1);
      expected_medians.push_back(r);
      // edge fill: repeat the final median w-1 times
      if (last) begin
        for (i = 1; i < w; i++) begin
          r.last = (i == w - 1);
          expected_medians.push_back(r);
        end
      end
    end
    if (last)
      fill_cnt = 0;
  endtask

  // accept side: predict on every input transaction, check every result
  always @(posedge clk) begin : monitor
    median_item_t exp_r;
    in_took  = rst_n && in_ch.valid && in_ch.ready;
    out_took = rst_n && out_ch.valid && out_ch.ready;
    if (in_took)
      compute_medians(in_ch.sample_in, in_ch.last_sample);
    if (out_took) begin
      if (expected_medians.size() == 0) begin
        $display("%0t: unexpected result, median_out %h last_result %b",
                 $time, out_ch.median_out, out_ch.last_result);
        errors++;
      end else begin
        exp_r = expected_medians.pop_front();
        if (out_ch.median_out !== exp_r.median) begin
          $display("%0t: median_out expected %h actual %h",
                   $time, exp_r.median, out_ch.median_out);
          errors++;
        end
        if (out_ch.last_result !== exp_r.last) begin
          $display("%0t: last_result expected %b actual %b",
                   $time, exp_r.last, out_ch.last_result);
          errors++;
        end
      end
    end
  end

  // sample driver: holds an item until taken, then waits its drawn gap
  always @(negedge clk) begin : driver
    sample_item_t item;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_gap = 0;
    end else if (!in_ch.valid || in_took) begin
      if (in_gap > 0) begin
        in_ch.valid <= 1'b0;
        in_gap--;
      end else if (sample_backlog.size() != 0) begin
        item = sample_backlog.pop_front();
        in_ch.valid       <= 1'b1;
        in_ch.sample_in   <= item.sample;
        in_ch.last_sample <= item.last;
        in_gap = $urandom_range(0, in_gap_max);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver: after each result transaction, stall for a drawn count
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_took)
        out_stall = $urandom_range(0, out_stall_max);
      if (out_stall > 0) begin
        out_ch.ready <= 1'b0;
        out_stall--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic push_item(input smf_pkg::sample_t s, input logic last);
    sample_item_t item;
    item.sample = s;
    item.last   = last;
    sample_backlog.push_back(item);
  endtask

  function automatic smf_pkg::sample_t draw_sample();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return smf_pkg::sample_t'($urandom_range(0, 7));   // plenty of ties
      4:       return smf_pkg::sample_t'($urandom_range(16'hFFF0, 16'hFFFF));
      default: return smf_pkg::sample_t'($urandom);
    endcase
  endfunction

  // random sequences; the final one may stay open into the next phase
  task automatic queue_stream(input int n);
    int left;
    int len;
    int w;
    int k;
    left = n;
    w = (cur_win == 0) ? 1 : int'(cur_win);
    while (left > 0) begin
      case ($urandom_range(0, 9))
        0, 1:    len = $urandom_range(1, (w > 1) ? w - 1 : 1);   // too short
        8, 9:    len = $urandom_range(16, 30);                   // saturates the count
        default: len = $urandom_range(w, w + 10);
      endcase
      for (k = 0; k < len && left > 0; k++) begin
        push_item(draw_sample(), k == len - 1);
        left--;
      end
    end
  endtask

  // all items taken, all results seen, then let the pipe settle
  task automatic wait_idle();
    do @(posedge clk); while (sample_backlog.size() != 0 || in_ch.valid);
    while (expected_medians.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // window size write, only ever issued while the block is idle
  task automatic write_window(input smf_pkg::win_t w);
    @(negedge clk);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.window_size <= w;
    do @(posedge clk); while (!cfg_ch.ready);
    cur_win = w;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin : stimulus
    int valid_done;
    int phase;
    int n;
    // every input known from time zero
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.sample_in    = '0;
    in_ch.last_sample  = 1'b0;
    out_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.window_size = '0;
    in_took            = 1'b0;
    out_took           = 1'b0;
    errors             = 0;
    cycle_cnt          = 0;
    in_gap_max         = 0;
    out_stall_max      = 0;
    fill_cnt           = 0;
    cur_win            = smf_pkg::win_t'(smf_pkg::RESET_WINDOW);
    foreach (win_hist[i])
      win_hist[i] = '0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset window of three: full windows over the sample extremes
    push_item(16'hFFFF, 1'b0);
    push_item(16'h0000, 1'b0);
    push_item(16'h8000, 1'b0);
    push_item(16'h7FFF, 1'b0);
    push_item(16'hAAAA, 1'b0);
    push_item(16'h5555, 1'b1);
    // short sequence and a lone sample give nothing
    push_item(16'h0001, 1'b0);
    push_item(16'hFFFE, 1'b1);
    push_item(16'h1234, 1'b1);
    wait_idle();

    // identical samples against a stalling receiver
    out_stall_max = 16;
    push_item(16'hFFFF, 1'b0);
    push_item(16'hFFFF, 1'b0);
    push_item(16'hFFFF, 1'b1);
    // leave a sequence open, then widen the window under it
    push_item(16'h0100, 1'b0);
    push_item(16'h0200, 1'b0);
    push_item(16'h0300, 1'b0);
    push_item(16'h0400, 1'b0);
    wait_idle();
    write_window(4'd5);
    push_item(16'h0050, 1'b0);
    push_item(16'h0060, 1'b1);
    wait_idle();

    // window of one, with and without the last flag
    write_window(4'd1);
    push_item(16'h0000, 1'b1);
    push_item(16'hFFFF, 1'b0);
    push_item(16'h4321, 1'b1);
    wait_idle();

    // random part, cycling through the window plan
    valid_done = 0;
    phase      = 0;
    while (valid_done < RANDOM_ITEMS) begin
      write_window(WIN_PLAN[phase % $size(WIN_PLAN)]);
      in_gap_max    = PACE[$urandom_range(0, 2)];
      out_stall_max = PACE[$urandom_range(0, 2)];
      // even sizes give no results, so keep those phases short
      n = cur_win[0] ? PHASE_ITEMS : DEAD_ITEMS;
      queue_stream(n);
      wait_idle();
      if (cur_win[0])
        valid_done += n;
      phase++;
    end

    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
